/* hw/rtl/bsrc_pkg.sv */
// ----------------------------------------------------------------------------
// Bitset range count and scan: shared package
// Sizes of the selection store, item field widths, item kinds, the item
// structs of both channels, and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bsrc_pkg;

  // Store geometry.
  localparam int STORE_BITS       = 4096;
  localparam int WORD_BITS        = 32;
  localparam int MAX_SCAN_RESULTS = 64;
  localparam int NUM_WORDS        = STORE_BITS / WORD_BITS;
  localparam int WIDX_W           = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int OFF_W            = $clog2(WORD_BITS);
  localparam int BIT_W            = WIDX_W + OFF_W;
  localparam int POP_W            = OFF_W + 1;

  // Range arithmetic must hold start plus length and the store size itself.
  localparam int RNG_W = ($clog2(STORE_BITS + 1) > 14) ? $clog2(STORE_BITS + 1) : 14;

  // Scan hit buffer.
  localparam int HIT_AW = (MAX_SCAN_RESULTS > 1) ? $clog2(MAX_SCAN_RESULTS) : 1;
  localparam int NCNT_W = $clog2(MAX_SCAN_RESULTS + 1);

  // Item field widths.
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 7;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  localparam int TOTAL_W = 13;
  localparam int POS_W   = 12;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SELECT = 2'd1,
    KIND_COUNT  = 2'd2,
    KIND_SCAN   = 2'd3
  } kind_t;

  // Input item.
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [INDEX_W-1:0]   word_index;
    logic [WORD_BITS-1:0] word_data;
    logic [START_W-1:0]   range_start;
    logic [LEN_W-1:0]     range_length;
  } op_t;

  // Result item.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [POS_W-1:0]   position;
    logic               found;
    logic               clipped;
    logic               last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the range of the input item
    logic wr_word;    // load one store word from the input item
    logic rd_issue;   // read the store word at the read pointer
    logic walk_sel;   // OR the range mask into the returned word
    logic walk_cnt;   // add the popcount of the returned word
    logic scan_load;  // load the returned word into the scan register
    logic scan_push;  // record the lowest set bit and clear it
    logic scan_more;  // a set bit remains past the result limit
    logic hit_rd;     // read the next recorded position
    logic out_cnt;    // load a count result
    logic out_hit;    // load a scan hit result
    logic out_empty;  // load a scan result without hit
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_empty;
    logic rd_at_last;
    logic scan_zero;
    logic scan_last_word;
    logic hits_full;
    logic hits_none;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

/* hw/rtl/bsrc_ctrl.sv */
// ----------------------------------------------------------------------------
// Bitset range count and scan: controller
// Sequences one item at a time: word writes, the streaming word walk of
// select and count, the bit-by-bit scan, and delivery of results.
// ----------------------------------------------------------------------------
module bsrc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          op_valid,
  input  logic [bsrc_pkg::KIND_W-1:0]   kind,
  input  bsrc_pkg::stat_t               stat,
  output logic                          op_stall,
  output bsrc_pkg::cmd_t                cmd
);
  import bsrc_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_WALK     = 10'b00_0000_0010,
    ST_WALK_END = 10'b00_0000_0100,
    ST_CNT_OUT  = 10'b00_0000_1000,
    ST_SCAN_RD  = 10'b00_0001_0000,
    ST_SCAN_LD  = 10'b00_0010_0000,
    ST_SCAN_BIT = 10'b00_0100_0000,
    ST_EMIT_NIL = 10'b00_1000_0000,
    ST_EMIT_RD  = 10'b01_0000_0000,
    ST_EMIT_LD  = 10'b10_0000_0000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [KIND_W-1:0] kind_q;
  logic              is_sel;

  assign is_sel   = (kind_q == KIND_SELECT);
  assign op_stall = (state != ST_IDLE);

  // Remember the kind of the item at work.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q <= kind;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (op_valid) begin
          cmd.accept = 1'b1;
          unique case (kind)
            KIND_WRITE: begin
              cmd.wr_word = 1'b1;
            end
            KIND_SELECT: begin
              if (!stat.range_empty) begin
                state_next = ST_WALK;
              end
            end
            KIND_COUNT: begin
              state_next = stat.range_empty ? ST_CNT_OUT : ST_WALK;
            end
            KIND_SCAN: begin
              state_next = stat.range_empty ? ST_EMIT_NIL : ST_SCAN_RD;
            end
          endcase
        end
      end
      // Stream one word read per cycle; the word read before returns now.
      ST_WALK: begin
        cmd.rd_issue = 1'b1;
        cmd.walk_sel = is_sel;
        cmd.walk_cnt = !is_sel;
        if (stat.rd_at_last) begin
          state_next = ST_WALK_END;
        end
      end
      ST_WALK_END: begin
        cmd.walk_sel = is_sel;
        cmd.walk_cnt = !is_sel;
        state_next   = is_sel ? ST_IDLE : ST_CNT_OUT;
      end
      ST_CNT_OUT: begin
        if (stat.out_free) begin
          cmd.out_cnt = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_SCAN_LD;
      end
      ST_SCAN_LD: begin
        cmd.scan_load = 1'b1;
        state_next    = ST_SCAN_BIT;
      end
      // Take one set bit per cycle until the word is used up or the result limit is reached.
      ST_SCAN_BIT: begin
        if (stat.scan_zero) begin
          if (!stat.scan_last_word) begin
            state_next = ST_SCAN_RD;
          end else if (stat.hits_none) begin
            state_next = ST_EMIT_NIL;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end else if (stat.hits_full) begin
          cmd.scan_more = 1'b1;
          state_next    = ST_EMIT_RD;
        end else begin
          cmd.scan_push = 1'b1;
        end
      end
      ST_EMIT_NIL: begin
        if (stat.out_free) begin
          cmd.out_empty = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        cmd.hit_rd = 1'b1;
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.out_hit = 1'b1;
          state_next  = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/bsrc_dp.sv */
// ----------------------------------------------------------------------------
// Bitset range count and scan: datapath
// Holds the selection store with its per-word valid bits, the range
// registers, the word mask and popcount logic, the lowest-set-bit scanner,
// the buffer of scan hits and the result register.
// ----------------------------------------------------------------------------
module bsrc_dp (
  input  logic            clk,
  input  logic            rst,
  input  bsrc_pkg::op_t   op,
  input  bsrc_pkg::cmd_t  cmd,
  input  logic            res_stall,
  output bsrc_pkg::stat_t stat,
  output logic            res_valid,
  output bsrc_pkg::res_t  res
);
  import bsrc_pkg::*;

  localparam logic [RNG_W-1:0]     STORE_LIM = RNG_W'(STORE_BITS);
  localparam logic [WORD_BITS-1:0] ONES      = '1;
  localparam logic [OFF_W-1:0]     TOP_OFF   = OFF_W'(WORD_BITS - 1);

  // Popcount of one word as a five-level adder tree.
  function automatic logic [POP_W-1:0] pop32(input logic [WORD_BITS-1:0] w);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) l1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
    for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

  // Range of the input item, clipped to the store.
  logic [RNG_W-1:0]  s_ext;
  logic [RNG_W-1:0]  e_sum;
  logic [RNG_W-1:0]  e_clip;
  logic [RNG_W-1:0]  e_m1;
  logic              rng_ovr;

  always_comb begin
    s_ext = RNG_W'(op.range_start);
    e_sum = s_ext + RNG_W'(op.range_length);
    if (s_ext >= STORE_LIM) begin
      e_clip  = s_ext;
      rng_ovr = (op.range_length != '0);
    end else if (e_sum > STORE_LIM) begin
      e_clip  = STORE_LIM;
      rng_ovr = 1'b1;
    end else begin
      e_clip  = e_sum;
      rng_ovr = 1'b0;
    end
    e_m1 = e_clip - RNG_W'(1);
  end

  // Range registers and per-item counters.
  logic [WIDX_W-1:0]  first_w;
  logic [WIDX_W-1:0]  last_w;
  logic [OFF_W-1:0]   start_off;
  logic [OFF_W-1:0]   end_off;
  logic [BIT_W-1:0]   start_q;
  logic               clip;
  logic [TOTAL_W-1:0] acc;
  logic [NCNT_W-1:0]  n_hits;
  logic [NCNT_W-1:0]  k_out;
  logic [WIDX_W-1:0]  rd_w;
  logic [WIDX_W-1:0]  dw;
  logic               rdv;

  // Store with valid bits; a word never written reads as zero.
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld;
  logic [WORD_BITS-1:0] mem_q;
  logic                 vld_q;
  logic                 mem_we;
  logic [WIDX_W-1:0]    mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic                 widx_ok;

  // Word mask and returned data.
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] rng_mask;
  logic [WORD_BITS-1:0] word_in;
  logic [WORD_BITS-1:0] masked;
  logic [TOTAL_W:0]     acc_sum;

  // Scanner.
  logic [WORD_BITS-1:0] sreg;
  logic [WIDX_W-1:0]    sw;
  logic [WORD_BITS-1:0] low_one;
  logic [OFF_W-1:0]     low_idx;
  logic [BIT_W-1:0]     abs_pos;
  logic [POS_W-1:0]     rel_pos;

  // Hit buffer.
  logic [POS_W-1:0] hit_mem [MAX_SCAN_RESULTS];
  logic [POS_W-1:0] hit_q;

  assign widx_ok = (32'(op.word_index) < 32'(NUM_WORDS));

  // Latch the range and clear the counters when an item is taken.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      first_w   <= WIDX_W'(s_ext >> OFF_W);
      last_w    <= WIDX_W'(e_m1 >> OFF_W);
      start_off <= s_ext[OFF_W-1:0];
      end_off   <= e_m1[OFF_W-1:0];
      start_q   <= BIT_W'(s_ext);
      acc       <= '0;
      n_hits    <= '0;
      k_out     <= '0;
    end else begin
      if (cmd.walk_cnt && rdv) begin
        acc <= acc_sum[TOTAL_W] ? TOTAL_MAX : acc_sum[TOTAL_W-1:0];
      end
      if (cmd.scan_push) begin
        n_hits <= n_hits + NCNT_W'(1);
      end
      if (cmd.out_hit) begin
        k_out <= k_out + NCNT_W'(1);
      end
    end
  end

  // Clip flag: set at accept from the overrun, raised later by a cut scan.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      clip <= rng_ovr;
    end else if (cmd.scan_more) begin
      clip <= 1'b1;
    end
  end

  // Read pointer walks from the first word; dw tags the returned word.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_w <= WIDX_W'(s_ext >> OFF_W);
    end else if (cmd.rd_issue) begin
      rd_w <= rd_w + WIDX_W'(1);
    end
    if (cmd.rd_issue) begin
      dw <= rd_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rdv <= 1'b0;
    end else begin
      rdv <= cmd.rd_issue;
    end
  end

  // Mask of the range bits within the returned word.
  always_comb begin
    lo_mask  = (dw == first_w) ? (ONES << start_off) : ONES;
    hi_mask  = (dw == last_w) ? (ONES >> (TOP_OFF - end_off)) : ONES;
    rng_mask = lo_mask & hi_mask;
    word_in  = vld_q ? mem_q : '0;
    masked   = word_in & rng_mask;
    acc_sum  = {1'b0, acc} + (TOTAL_W + 1)'(pop32(masked));
  end

  // Store write port: word writes, and the read-modify-write of select.
  always_comb begin
    mem_we = (cmd.wr_word && widx_ok) || (cmd.walk_sel && rdv);
    mem_wa = cmd.wr_word ? WIDX_W'(op.word_index) : dw;
    mem_wd = cmd.wr_word ? op.word_data : (word_in | rng_mask);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_issue) begin
      mem_q <= mem[rd_w];
      vld_q <= vld[rd_w];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[mem_wa] <= 1'b1;
    end
  end

  // Lowest set bit of the scan register and its offset from the range start.
  always_comb begin
    low_one = sreg & (~sreg + WORD_BITS'(1));
    low_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_one[i]) begin
        low_idx = low_idx | OFF_W'(i);
      end
    end
    abs_pos = {sw, low_idx};
    rel_pos = POS_W'(abs_pos - start_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_load) begin
      sreg <= masked;
      sw   <= dw;
    end else if (cmd.scan_push) begin
      sreg <= sreg & (sreg - WORD_BITS'(1));
    end
  end

  // Hit buffer: filled by the scan, read back in order for delivery.
  always_ff @(posedge clk) begin
    if (cmd.scan_push) begin
      hit_mem[n_hits[HIT_AW-1:0]] <= rel_pos;
    end
    if (cmd.hit_rd) begin
      hit_q <= hit_mem[k_out[HIT_AW-1:0]];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_cnt || cmd.out_hit || cmd.out_empty) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_cnt) begin
      res.total    <= acc;
      res.position <= '0;
      res.found    <= 1'b0;
      res.clipped  <= 1'b0;
      res.last     <= 1'b1;
    end else if (cmd.out_hit) begin
      res.total    <= '0;
      res.position <= hit_q;
      res.found    <= 1'b1;
      res.clipped  <= clip;
      res.last     <= stat.emit_last;
    end else if (cmd.out_empty) begin
      res.total    <= '0;
      res.position <= '0;
      res.found    <= 1'b0;
      res.clipped  <= clip;
      res.last     <= 1'b1;
    end
  end

  // Status to the controller.
  always_comb begin
    stat.range_empty    = (e_clip == s_ext);
    stat.rd_at_last     = (rd_w == last_w);
    stat.scan_zero      = (sreg == '0);
    stat.scan_last_word = (sw == last_w);
    stat.hits_full      = (n_hits == NCNT_W'(MAX_SCAN_RESULTS));
    stat.hits_none      = (n_hits == '0);
    stat.emit_last      = ((k_out + NCNT_W'(1)) == n_hits);
    stat.out_free       = !res_valid || !res_stall;
  end

endmodule

/* hw/rtl/bitset_range_count_scan_top.sv */
// ----------------------------------------------------------------------------
// Bitset range count and scan: top level
// Selection bitset of 32-bit words with word write, range select, range
// popcount and range scan of set-bit positions.
// ----------------------------------------------------------------------------
// The block takes one item at a time and stalls its input until the item's
// work is done; the result register lets the next item in while the last
// result still waits. Select and count walk the range word by word through
// the single store read port, streaming one word per cycle, and count then
// waits for the result register. A scan reads and loads each word and checks
// for an empty scan register, records set bits up to the result limit of 64,
// then reads back and delivers each result; the scanner extracts one set bit
// per cycle. Words never written read as zero through per-word valid bits, so
// the block is ready right after reset.
// ----------------------------------------------------------------------------
module bitset_range_count_scan_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            op_valid,
  output logic            op_stall,
  input  bsrc_pkg::op_t   op,
  output logic            res_valid,
  input  logic            res_stall,
  output bsrc_pkg::res_t  res
);
  import bsrc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller.
  bsrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .kind     (op.kind),
    .stat     (stat),
    .op_stall (op_stall),
    .cmd      (cmd)
  );

  // Datapath.
  bsrc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cmd       (cmd),
    .res_stall (res_stall),
    .stat      (stat),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

/* sim/bitset_range_count_scan_top_tb.sv */
// ----------------------------------------------------------------------------
// Bitset range count and scan: testbench
// Drives word writes, range selects, range counts and range scans into the
// block with random gaps and output stalls. A behavioral copy of the
// selection store predicts every result, and a monitor compares each
// delivered result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bitset_range_count_scan_top_tb;
  import bsrc_pkg::*;

  localparam int RANDOM_ITEMS    = 96;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PRESSURE_CYCLES = 400;
  localparam int PRESSURE_AFTER  = 30;
  localparam int DRAIN_CYCLES    = 500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic op_valid = 1'b0;
  logic op_stall;
  op_t  op = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  // Behavioral copy of the selection store.
  logic [WORD_BITS-1:0] sel_words [NUM_WORDS];

  op_t  pending_ops [$];
  res_t expected_res [$];

  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned ops_taken = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;

  bitset_range_count_scan_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op        (op),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Wait before the next item: runs of items with no wait alternate with
  // runs of random waits.
  function automatic int unsigned draw_wait(input int unsigned count);
    if ((count / 25) % 3 == 1) return 0;
    return $urandom_range(0, 13);
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at result %0d: %s", results_seen, what);
    errors++;
  endtask

  // Update the store copy for one item and queue the results it causes.
  task automatic predict_item(input op_t it);
    int unsigned start_bit;
    int unsigned end_bit;
    int unsigned p;
    int unsigned set_count;
    bit          overrun;
    bit          more;
    res_t        r;
    res_t        hits [$];
    start_bit = 32'(it.range_start);
    overrun   = 1'b0;
    more      = 1'b0;
    set_count = 0;
    if (start_bit >= STORE_BITS) begin
      end_bit = start_bit;
      overrun = it.range_length != 0;
    end else begin
      end_bit = start_bit + 32'(it.range_length);
      if (end_bit > STORE_BITS) begin
        end_bit = STORE_BITS;
        overrun = 1'b1;
      end
    end
    case (it.kind)
      KIND_WRITE: begin
        if (it.word_index < NUM_WORDS) sel_words[it.word_index] = it.word_data;
      end
      KIND_SELECT: begin
        for (p = start_bit; p < end_bit; p++) sel_words[p / WORD_BITS][p % WORD_BITS] = 1'b1;
      end
      KIND_COUNT: begin
        for (p = start_bit; p < end_bit; p++) begin
          if (sel_words[p / WORD_BITS][p % WORD_BITS] && set_count < 32'(TOTAL_MAX))
            set_count++;
        end
        r = '0;
        r.total = TOTAL_W'(set_count);
        r.last  = 1'b1;
        expected_res.push_back(r);
      end
      default: begin
        for (p = start_bit; p < end_bit; p++) begin
          if (sel_words[p / WORD_BITS][p % WORD_BITS]) begin
            if (hits.size() >= MAX_SCAN_RESULTS) begin
              more = 1'b1;
              break;
            end
            r = '0;
            r.position = POS_W'(p - start_bit);
            r.found    = 1'b1;
            hits.push_back(r);
          end
        end
        if (hits.size() == 0) begin
          r = '0;
          r.clipped = overrun || more;
          r.last    = 1'b1;
          expected_res.push_back(r);
        end else begin
          foreach (hits[k]) begin
            r = hits[k];
            r.clipped = overrun || more;
            r.last    = (k == hits.size() - 1);
            expected_res.push_back(r);
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (expected_res.size() == 0) begin
      report_mismatch($sformatf("result with none expected: total %0d position %0d found %0b",
                                got.total, got.position, got.found));
      return;
    end
    want = expected_res.pop_front();
    check_field("total", 32'(got.total), 32'(want.total));
    check_field("position", 32'(got.position), 32'(want.position));
    check_field("found", 32'(got.found), 32'(want.found));
    check_field("clipped", 32'(got.clipped), 32'(want.clipped));
    check_field("last", 32'(got.last), 32'(want.last));
  endtask

  // Item with every field random, so that fields a kind ignores still toggle.
  function automatic op_t rand_op();
    op_t it;
    it.kind         = KIND_W'($urandom_range(0, 3));
    it.word_index   = INDEX_W'($urandom_range(0, NUM_WORDS - 1));
    it.word_data    = $urandom;
    it.range_start  = START_W'($urandom_range(0, STORE_BITS - 1));
    it.range_length = LEN_W'($urandom_range(0, STORE_BITS));
    return it;
  endfunction

  function automatic op_t make_write(input int unsigned idx, input logic [31:0] data);
    op_t it;
    it = rand_op();
    it.kind       = KIND_WRITE;
    it.word_index = INDEX_W'(idx);
    it.word_data  = data;
    return it;
  endfunction

  function automatic op_t make_range(input kind_t k, input int unsigned start_bit,
                                     input int unsigned len);
    op_t it;
    it = rand_op();
    it.kind         = k;
    it.range_start  = START_W'(start_bit);
    it.range_length = LEN_W'(len);
    return it;
  endfunction

  // Ranges are mostly short, some medium, and a few run past the store end.
  function automatic op_t rand_range(input kind_t k);
    int unsigned sel;
    int unsigned start_bit;
    int unsigned len;
    sel = $urandom_range(0, 9);
    start_bit = $urandom_range(0, STORE_BITS - 1);
    if (sel < 6) len = $urandom_range(0, 96);
    else if (sel < 8) len = $urandom_range(0, 700);
    else if (sel == 8) begin
      start_bit = $urandom_range(STORE_BITS - 300, STORE_BITS - 1);
      len = $urandom_range(0, STORE_BITS);
    end else len = ($urandom_range(0, 1) == 0) ? STORE_BITS : $urandom_range(0, STORE_BITS);
    return make_range(k, start_bit, len);
  endfunction

  // Word contents range from empty and full to sparse and dense.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return $urandom & $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: directed items first, then random episodes of writes, an
  // optional select and a few queries, mixed with fully random items.
  initial begin : p_stimulus
    int unsigned made;
    int unsigned nq;
    foreach (sel_words[i]) sel_words[i] = '0;

    // Empty store.
    pending_ops.push_back(make_range(KIND_COUNT, 0, STORE_BITS));
    pending_ops.push_back(make_range(KIND_SCAN, 0, STORE_BITS));
    // Exactly the result limit, then one more set bit just past it.
    pending_ops.push_back(make_write(0, 32'hFFFF_FFFF));
    pending_ops.push_back(make_write(1, 32'hFFFF_FFFF));
    pending_ops.push_back(make_range(KIND_SCAN, 0, 64));
    pending_ops.push_back(make_range(KIND_SCAN, 0, 65));
    pending_ops.push_back(make_write(2, 32'h0000_0001));
    pending_ops.push_back(make_range(KIND_SCAN, 0, 65));
    // Last word of the store and ranges that overrun it.
    pending_ops.push_back(make_write(NUM_WORDS - 1, 32'h0000_0001));
    pending_ops.push_back(make_range(KIND_SELECT, STORE_BITS - 2, STORE_BITS));
    pending_ops.push_back(make_range(KIND_SCAN, STORE_BITS - 36, 100));
    pending_ops.push_back(make_range(KIND_COUNT, STORE_BITS - 1, 1));
    // Empty ranges.
    pending_ops.push_back(make_range(KIND_COUNT, STORE_BITS - 1, 0));
    pending_ops.push_back(make_range(KIND_SCAN, 100, 0));
    // Select inside a word keeps the bits around it.
    pending_ops.push_back(make_write(10, 32'h8000_0001));
    pending_ops.push_back(make_range(KIND_SELECT, 330, 5));
    pending_ops.push_back(make_range(KIND_SCAN, 320, 32));
    // Partial word at both ends.
    pending_ops.push_back(make_range(KIND_COUNT, 3, 2));
    pending_ops.push_back(make_write(5, 32'hA5A5_A5A5));
    pending_ops.push_back(make_range(KIND_COUNT, 1, STORE_BITS));
    pending_ops.push_back(make_range(KIND_COUNT, 0, STORE_BITS));
    // Select across words, then a scan clipped by the result limit.
    pending_ops.push_back(make_range(KIND_SELECT, 100, 100));
    pending_ops.push_back(make_range(KIND_SCAN, 0, STORE_BITS));
    pending_ops.push_back(make_range(KIND_SCAN, 161, 7));

    made = 0;
    while (made < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 2) begin
        pending_ops.push_back(rand_op());
        made++;
      end else begin
        repeat ($urandom_range(0, 3)) begin
          pending_ops.push_back(make_write($urandom_range(0, NUM_WORDS - 1), rand_word()));
          made++;
        end
        if ($urandom_range(0, 1) == 0) begin
          pending_ops.push_back(rand_range(KIND_SELECT));
          made++;
        end
        nq = $urandom_range(1, 3);
        repeat (nq) begin
          pending_ops.push_back(rand_range(($urandom_range(0, 1) == 0) ? KIND_COUNT : KIND_SCAN));
          made++;
        end
      end
    end

    // Drain: everything sent and every expected result delivered.
    @(negedge clk);
    while (rst || pending_ops.size() != 0 || op_valid || expected_res.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("bitset_range_count_scan_top: match");
    end else begin
      $display("bitset_range_count_scan_top: mismatch");
    end
    $finish;
  end

  // Input driver: presents queued items, with a random wait after each one.
  always @(posedge clk) begin : p_driver
    int unsigned gap;
    if (rst) begin
      op_valid <= 1'b0;
      gap_left <= 0;
    end else if (op_valid && !op_stall) begin
      predict_item(op);
      ops_taken++;
      gap = draw_wait(ops_taken);
      if (gap == 0 && pending_ops.size() != 0) begin
        op <= pending_ops.pop_front();
      end else begin
        op_valid <= 1'b0;
        gap_left <= (gap > 0) ? gap - 1 : 0;
      end
    end else if (!op_valid) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() != 0) begin
        op       <= pending_ops.pop_front();
        op_valid <= 1'b1;
      end
    end
  end

  // Long hold-off on the result side, once, so the block backs up its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= PRESSURE_AFTER) begin
      hold_left <= PRESSURE_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: checks each delivered result and stalls at random after it.
  always @(posedge clk) begin : p_monitor
    int unsigned next_left;
    if (rst) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      next_left = stall_left;
      if (res_valid && !res_stall) begin
        check_result(res);
        results_seen <= results_seen + 1;
        next_left = draw_wait(results_seen);
      end else if (next_left != 0) begin
        next_left = next_left - 1;
      end
      stall_left <= next_left;
      res_stall  <= (hold_left != 0) || (next_left != 0);
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((op_valid && !op_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("bitset_range_count_scan_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
